>>> hw/rtl/uvsg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the UV sphere vertex generator.
// Depends on nothing; every other file of the block imports it.
package uvsg_pkg;

  // Segment range and configuration map
  localparam int SEG_W      = 9;
  localparam int RADIUS_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS = 1'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;
  localparam logic [SEG_W-1:0]    SEG_RST    = 9'd16;
  localparam logic [SEG_W-1:0]    SEG_MIN    = 9'd3;
  localparam logic [SEG_W-1:0]    SEG_MAX    = 9'd256;

  // Long division of an index by the segment count
  localparam int REM_W          = 8;
  localparam int HALF_W         = 8;
  localparam int FRAC_W         = 32;
  localparam int Q_W            = FRAC_W + 1;
  localparam int PP_W           = Q_W + 1;
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = FRAC_W / BITS_PER_STAGE;
  localparam int TEX_FRAC       = 16;
  localparam int Q16_STAGE      = TEX_FRAC / BITS_PER_STAGE;
  localparam int TEX_W          = TEX_FRAC + 1;

  // Sine evaluation, Q30 magnitudes
  localparam int PHASE_W = 32;
  localparam int MAG_W   = 31;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int QS_LAT  = 6;

  localparam logic [MAG_W-1:0]  Q30_ONE = 31'h4000_0000;
  localparam logic [PROD_W-1:0] RND30   = 62'h0000_0000_2000_0000;
  localparam logic [MAG_W-1:0]  COEF_C1 = 31'd1686629713;
  localparam logic [MAG_W-1:0]  COEF_C3 = 31'd693598668;
  localparam logic [MAG_W-1:0]  COEF_C5 = 31'd85569274;
  localparam logic [MAG_W-1:0]  COEF_C7 = 31'd5026991;
  localparam logic [MAG_W-1:0]  COEF_C9 = 31'd172272;

  // Outputs
  localparam int POS_W  = 17;
  localparam int NORM_W = 16;
  localparam int PPROD_W = RADIUS_W + MAG_W;
  localparam logic [TEX_W-1:0]         TEX_ONE  = 17'd65536;
  localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd16384;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // One lane of the divider: quotient so far, remainder, and the 17-bit snapshot
  typedef struct packed {
    logic [Q_W-1:0]   q;
    logic [REM_W-1:0] rem;
    logic [TEX_W-1:0] q16;
    logic [REM_W-1:0] r16;
  } div_lane_t;

  typedef struct packed {
    div_lane_t row;
    div_lane_t col;
    logic      clamped;
  } div_item_t;

  // Beat handed from front to back through the queue
  typedef struct packed {
    logic [PHASE_W-1:0] pt;
    logic [PHASE_W-1:0] pp;
    logic [TEX_W-1:0]   tex_u;
    logic [TEX_W-1:0]   tex_v;
    logic               clamped;
  } phase_item_t;

  // Fields that ride alongside the sine pipeline
  typedef struct packed {
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic             clamped;
  } side_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // Four restoring division steps: one quotient bit per step
  function automatic div_lane_t div_step(div_lane_t a, logic [SEG_W-1:0] s);
    div_lane_t        o;
    logic [SEG_W-1:0] t;
    o = a;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      t = {o.rem, 1'b0};
      if (t >= s) begin
        o.rem = REM_W'(t - s);
        o.q   = {o.q[Q_W-2:0], 1'b1};
      end else begin
        o.rem = t[REM_W-1:0];
        o.q   = {o.q[Q_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

>>> hw/rtl/uvsg_front.sv
`timescale 1ns / 1ps
// Front end: accepts row/col beats, clamps them and divides by the segment count.
// Produces the two angle phases and the texture coordinates. Uses uvsg_pkg.
module uvsg_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [uvsg_pkg::SEG_W-1:0]  in_row,
  input  logic [uvsg_pkg::SEG_W-1:0]  in_col,
  input  logic [uvsg_pkg::SEG_W-1:0]  seg,
  input  uvsg_pkg::fifo_stat_t        fstat,
  output logic                        push,
  output uvsg_pkg::phase_item_t       push_item
);
  import uvsg_pkg::*;

  logic                  adv;
  logic [HALF_W-1:0]     half;
  logic [SEG_W-1:0]      row_c;
  logic [SEG_W-1:0]      col_c;
  logic                  row_big;
  logic                  col_big;
  div_item_t             st_r   [0:DIV_STAGES];
  div_item_t             st_nxt [0:DIV_STAGES];
  logic [DIV_STAGES:0]   v_r;
  phase_item_t           res_r;
  phase_item_t           res_nxt;
  logic                  res_v_r;
  logic                  corr_c;
  logic                  corr16_c;
  logic                  corr16_v;
  logic [PP_W-1:0]       pp_sum;

  // Whole front advances unless its last beat cannot enter the queue
  assign adv       = !(res_v_r && fstat.full);
  assign in_stall  = !adv;
  assign push      = res_v_r && !fstat.full;
  assign push_item = res_r;
  assign half      = seg[SEG_W-1:1];

  // Clamp indexes above the segment count
  assign row_big = in_row > seg;
  assign col_big = in_col > seg;
  assign row_c   = row_big ? seg : in_row;
  assign col_c   = col_big ? seg : in_col;

  // Integer quotient bit, then four fraction bits per stage
  always_comb begin
    st_nxt[0].row.q     = {{FRAC_W{1'b0}}, row_c == seg};
    st_nxt[0].row.rem   = (row_c == seg) ? '0 : row_c[REM_W-1:0];
    st_nxt[0].row.q16   = '0;
    st_nxt[0].row.r16   = '0;
    st_nxt[0].col.q     = {{FRAC_W{1'b0}}, col_c == seg};
    st_nxt[0].col.rem   = (col_c == seg) ? '0 : col_c[REM_W-1:0];
    st_nxt[0].col.q16   = '0;
    st_nxt[0].col.r16   = '0;
    st_nxt[0].clamped   = row_big || col_big;
    for (int i = 1; i <= DIV_STAGES; i++) begin
      st_nxt[i].row     = div_step(st_r[i-1].row, seg);
      st_nxt[i].col     = div_step(st_r[i-1].col, seg);
      st_nxt[i].clamped = st_r[i-1].clamped;
      if (i == Q16_STAGE) begin
        st_nxt[i].row.q16 = st_nxt[i].row.q[TEX_W-1:0];
        st_nxt[i].row.r16 = st_nxt[i].row.rem;
        st_nxt[i].col.q16 = st_nxt[i].col.q[TEX_W-1:0];
        st_nxt[i].col.r16 = st_nxt[i].col.rem;
      end
    end
  end

  // Rounding corrections: remainder plus half a segment reaching a full one
  always_comb begin
    corr_c   = ({1'b0, st_r[DIV_STAGES].col.rem} + {1'b0, half}) >= seg;
    corr16_c = ({1'b0, st_r[DIV_STAGES].col.r16} + {1'b0, half}) >= seg;
    corr16_v = ({1'b0, st_r[DIV_STAGES].row.r16} + {1'b0, half}) >= seg;
    pp_sum   = {1'b0, st_r[DIV_STAGES].row.q} + PP_W'(1);
    res_nxt.pt      = PHASE_W'(st_r[DIV_STAGES].col.q + Q_W'(corr_c));
    res_nxt.pp      = pp_sum[PHASE_W:1];
    res_nxt.tex_u   = st_r[DIV_STAGES].col.q16 + TEX_W'(corr16_c);
    res_nxt.tex_v   = st_r[DIV_STAGES].row.q16 + TEX_W'(corr16_v);
    res_nxt.clamped = st_r[DIV_STAGES].clamped;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      res_v_r <= 1'b0;
    end else if (adv) begin
      v_r     <= {v_r[DIV_STAGES-1:0], in_valid};
      res_v_r <= v_r[DIV_STAGES];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= DIV_STAGES; i++) begin
        st_r[i] <= st_nxt[i];
      end
      res_r <= res_nxt;
    end
  end

endmodule

>>> hw/rtl/uvsg_fifo.sv
`timescale 1ns / 1ps
// Short queue that decouples the front end from the sine back end.
// Holds phase_item_t beats from uvsg_pkg.
module uvsg_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  uvsg_pkg::phase_item_t  push_item,
  input  logic                   pop,
  output uvsg_pkg::phase_item_t  head,
  output uvsg_pkg::fifo_stat_t   stat
);
  import uvsg_pkg::*;

  phase_item_t        mem_r [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic [FIFO_CW-1:0] cnt_nxt;

  assign stat.empty = cnt_r == '0;
  assign stat.full  = cnt_r == FIFO_CW'(FIFO_DEPTH);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CW'(1);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue fill count above depth");
`endif

endmodule

>>> hw/rtl/uvsg_qsine.sv
`timescale 1ns / 1ps
// Pipelined quarter-wave sine: odd polynomial in Q30, Horner form, six stages.
// Coefficients and widths come from uvsg_pkg.
module uvsg_qsine (
  input  logic                        clk,
  input  logic                        en,
  input  logic [uvsg_pkg::MAG_W-1:0]  x,
  output logic [uvsg_pkg::MAG_W-1:0]  y
);
  import uvsg_pkg::*;

  localparam logic [MAG_W-1:0] COEF_TAB [0:3] = '{COEF_C7, COEF_C5, COEF_C3, COEF_C1};

  logic [MAG_W-1:0]  x_d   [0:4];
  logic [MAG_W-1:0]  x2_d  [0:3];
  logic [MAG_W-1:0]  t_r   [0:3];
  logic [MAG_W-1:0]  t_nxt [0:3];
  logic [PROD_W-1:0] prod  [0:3];
  logic [PROD_W-1:0] sq;
  logic [PROD_W-1:0] prod_y;
  logic [PROD_W-1:0] y_full;
  logic [MAG_W-1:0]  y_r;
  logic [MAG_W-1:0]  y_nxt;

  assign y = y_r;

  // One multiply per stage
  always_comb begin
    sq      = (PROD_W'(x) * PROD_W'(x)) + RND30;
    prod[0] = PROD_W'(x2_d[0]) * PROD_W'(COEF_C9);
    for (int k = 1; k < 4; k++) begin
      prod[k] = PROD_W'(x2_d[k]) * PROD_W'(t_r[k-1]);
    end
    for (int k = 0; k < 4; k++) begin
      t_nxt[k] = COEF_TAB[k] - MAG_W'(prod[k] >> 30);
    end
    prod_y = PROD_W'(x_d[4]) * PROD_W'(t_r[3]);
    y_full = prod_y >> 30;
    y_nxt  = (y_full > PROD_W'(Q30_ONE)) ? Q30_ONE : MAG_W'(y_full);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_d[0]  <= x;
      x2_d[0] <= MAG_W'(sq >> 30);
      for (int k = 1; k < 5; k++) begin
        x_d[k] <= x_d[k-1];
      end
      for (int k = 1; k < 4; k++) begin
        x2_d[k] <= x2_d[k-1];
      end
      for (int k = 0; k < 4; k++) begin
        t_r[k] <= t_nxt[k];
      end
      y_r <= y_nxt;
    end
  end

endmodule

>>> hw/rtl/uvsg_back.sv
`timescale 1ns / 1ps
// Back end: sin/cos of both angles, direction products, radius scaling, output register.
// Instantiates four uvsg_qsine units; uses uvsg_pkg.
module uvsg_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  uvsg_pkg::fifo_stat_t                fstat,
  input  uvsg_pkg::phase_item_t               head,
  output logic                                pop,
  input  logic [uvsg_pkg::RADIUS_W-1:0]       radius,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [uvsg_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [uvsg_pkg::POS_W-1:0]   out_pos_y,
  output logic signed [uvsg_pkg::POS_W-1:0]   out_pos_z,
  output logic signed [uvsg_pkg::NORM_W-1:0]  out_norm_x,
  output logic signed [uvsg_pkg::NORM_W-1:0]  out_norm_y,
  output logic signed [uvsg_pkg::NORM_W-1:0]  out_norm_z,
  output logic [uvsg_pkg::TEX_W-1:0]          out_tex_u,
  output logic [uvsg_pkg::TEX_W-1:0]          out_tex_v,
  output logic                                out_clamped
);
  import uvsg_pkg::*;

  // Sine lanes
  localparam int L_ST = 0;
  localparam int L_CT = 1;
  localparam int L_SP = 2;
  localparam int L_CP = 3;
  localparam int F_STG   = QS_LAT + 1;
  localparam int OUT_STG = QS_LAT + 2;

  logic                     adv;
  logic [OUT_STG:0]         vb_r;
  logic [MAG_W-1:0]         x_r   [0:3];
  logic [MAG_W-1:0]         y     [0:3];
  logic [3:0]               sg_r  [0:QS_LAT];
  side_t                    side_r [0:F_STG];
  logic [MAG_W-1:0]         fm_r   [0:2];
  logic [MAG_W-1:0]         fm_nxt [0:2];
  logic [2:0]               fneg_r;
  logic [PROD_W-1:0]        fprod  [0:1];
  logic [PPROD_W-1:0]       pprod  [0:2];
  logic [POS_W-1:0]         pmag   [0:2];
  logic [MAG_W-1:0]         nsum   [0:2];
  logic signed [POS_W-1:0]  pos_r  [0:2];
  logic signed [NORM_W-1:0] norm_r [0:2];
  side_t                    oside_r;

  // Sine argument from the quadrant and the fraction of a phase
  function automatic logic [MAG_W-1:0] quad_arg(logic [1:0] q, logic [29:0] f);
    return q[0] ? (Q30_ONE - {1'b0, f}) : {1'b0, f};
  endfunction

  assign adv       = !(vb_r[OUT_STG] && out_stall);
  assign pop       = adv && !fstat.empty;
  assign out_valid = vb_r[OUT_STG];

  for (genvar g = 0; g < 4; g++) begin : g_sine
    uvsg_qsine u_qsine (
      .clk (clk),
      .en  (adv),
      .x   (x_r[g]),
      .y   (y[g])
    );
  end

  // Direction products (Q30), radius scaling and normals, rounded half away from zero
  always_comb begin
    fprod[0]      = PROD_W'(y[L_CT]) * PROD_W'(y[L_SP]) + RND30;
    fprod[1]      = PROD_W'(y[L_ST]) * PROD_W'(y[L_SP]) + RND30;
    fm_nxt[0]     = MAG_W'(fprod[0] >> 30);
    fm_nxt[1]     = y[L_CP];
    fm_nxt[2]     = MAG_W'(fprod[1] >> 30);
    for (int a = 0; a < 3; a++) begin
      pprod[a] = PPROD_W'(radius) * PPROD_W'(fm_r[a]) + PPROD_W'(RND30);
      pmag[a]  = POS_W'(pprod[a] >> 30);
      nsum[a]  = fm_r[a] + MAG_W'(1 << 15);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else if (adv) begin
      vb_r <= {vb_r[OUT_STG-1:0], !fstat.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Entry stage: quadrant folding for sin and cos of both angles
      x_r[L_ST] <= quad_arg(head.pt[31:30], head.pt[29:0]);
      x_r[L_CT] <= quad_arg(head.pt[31:30] + 2'd1, head.pt[29:0]);
      x_r[L_SP] <= quad_arg(head.pp[31:30], head.pp[29:0]);
      x_r[L_CP] <= quad_arg(head.pp[31:30] + 2'd1, head.pp[29:0]);
      sg_r[0]   <= {head.pp[31:30] + 2'd1 >= 2'd2, head.pp[31],
                    head.pt[31:30] + 2'd1 >= 2'd2, head.pt[31]};
      side_r[0] <= '{tex_u: head.tex_u, tex_v: head.tex_v, clamped: head.clamped};
      for (int k = 1; k <= QS_LAT; k++) begin
        sg_r[k] <= sg_r[k-1];
      end
      for (int k = 1; k <= F_STG; k++) begin
        side_r[k] <= side_r[k-1];
      end
      // Direction stage
      for (int a = 0; a < 3; a++) begin
        fm_r[a] <= fm_nxt[a];
      end
      fneg_r[0] <= sg_r[QS_LAT][L_CT] ^ sg_r[QS_LAT][L_SP];
      fneg_r[1] <= sg_r[QS_LAT][L_CP];
      fneg_r[2] <= sg_r[QS_LAT][L_ST] ^ sg_r[QS_LAT][L_SP];
      // Output register
      for (int a = 0; a < 3; a++) begin
        pos_r[a]  <= fneg_r[a] ? -$signed(pmag[a]) : $signed(pmag[a]);
        norm_r[a] <= fneg_r[a] ? -$signed(NORM_W'(nsum[a] >> 16))
                               : $signed(NORM_W'(nsum[a] >> 16));
      end
      oside_r <= side_r[F_STG];
    end
  end

  assign out_pos_x   = pos_r[0];
  assign out_pos_y   = pos_r[1];
  assign out_pos_z   = pos_r[2];
  assign out_norm_x  = norm_r[0];
  assign out_norm_y  = norm_r[1];
  assign out_norm_z  = norm_r[2];
  assign out_tex_u   = oside_r.tex_u;
  assign out_tex_v   = oside_r.tex_v;
  assign out_clamped = oside_r.clamped;

endmodule

>>> hw/rtl/uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps
// Top level of the UV sphere vertex generator: config registers, front, queue, back.
// Depends on uvsg_pkg, uvsg_front, uvsg_fifo, uvsg_qsine and uvsg_back.
//
// Usage: each input beat (in_row, in_col) is one grid point of the sphere; each
// output beat is its vertex: Q8.8 position, Q1.14 unit normal, Q1.16 texture
// coordinates and a flag set when row or col was above the segment count and
// clamped. A beat moves when valid is high and stall is low, on both channels.
// Throughput is one vertex per cycle while out_stall stays low. A beat passes
// through the divider front end (a 4-bit-per-stage restoring divider over 32
// fraction bits plus rounding), then the queue, then the back end (quadrant
// folding, six-stage sine polynomial, direction products, radius scaling into
// the output register). When out_stall holds a result, the back end freezes;
// the front keeps accepting until the four-entry queue fills, then raises
// in_stall. Reset clears all valid state and sets radius to 1.0 and segments
// to 16. Write cfg_idx 0 for radius, 1 for segments (clipped to 3..256) while
// the block is idle.
module uv_sphere_vertex_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [uvsg_pkg::SEG_W-1:0]          in_row,
  input  logic [uvsg_pkg::SEG_W-1:0]          in_col,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [uvsg_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [uvsg_pkg::POS_W-1:0]   out_pos_y,
  output logic signed [uvsg_pkg::POS_W-1:0]   out_pos_z,
  output logic signed [uvsg_pkg::NORM_W-1:0]  out_norm_x,
  output logic signed [uvsg_pkg::NORM_W-1:0]  out_norm_y,
  output logic signed [uvsg_pkg::NORM_W-1:0]  out_norm_z,
  output logic [uvsg_pkg::TEX_W-1:0]          out_tex_u,
  output logic [uvsg_pkg::TEX_W-1:0]          out_tex_v,
  output logic                                out_clamped,
  input  logic                                cfg_we,
  input  logic [uvsg_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [uvsg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import uvsg_pkg::*;

  logic [RADIUS_W-1:0] radius_r;
  logic [SEG_W-1:0]    seg_r;
  logic [SEG_W-1:0]    seg_clip;
  logic                push;
  logic                pop;
  phase_item_t         push_item;
  phase_item_t         head;
  fifo_stat_t          fstat;

  // Segment count held inside its legal range
  always_comb begin
    if (cfg_data[SEG_W-1:0] < SEG_MIN) begin
      seg_clip = SEG_MIN;
    end else if (cfg_data[SEG_W-1:0] > SEG_MAX) begin
      seg_clip = SEG_MAX;
    end else begin
      seg_clip = cfg_data[SEG_W-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      seg_r    <= SEG_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RADIUS:   radius_r <= cfg_data[RADIUS_W-1:0];
        REG_SEGMENTS: seg_r    <= seg_clip;
        default: begin
        end
      endcase
    end
  end

  uvsg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_row    (in_row),
    .in_col    (in_col),
    .seg       (seg_r),
    .fstat     (fstat),
    .push      (push),
    .push_item (push_item)
  );

  uvsg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (fstat)
  );

  uvsg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .fstat       (fstat),
    .head        (head),
    .pop         (pop),
    .radius      (radius_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_pos_z   (out_pos_z),
    .out_norm_x  (out_norm_x),
    .out_norm_y  (out_norm_y),
    .out_norm_z  (out_norm_z),
    .out_tex_u   (out_tex_u),
    .out_tex_v   (out_tex_v),
    .out_clamped (out_clamped)
  );

`ifndef SYNTHESIS
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    seg_r >= SEG_MIN && seg_r <= SEG_MAX)
    else $error("segment count out of range");
  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tex_u <= TEX_ONE && out_tex_v <= TEX_ONE)
    else $error("texture coordinate above one");
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_norm_y <= NORM_ONE && out_norm_y >= -NORM_ONE)
    else $error("normal component above unit length");
`endif

endmodule
